// ===== src/sgr_pkg.sv =====
package sgr_pkg;

  localparam int HoldDepthDef = 16;
  localparam int RefBitsDef   = 16;

  localparam logic [7:0] DRAIN_RESET = 8'd10;
  localparam int         RES_CNT_W   = 5;
  localparam logic [RES_CNT_W-1:0] MAX_RES = 5'd16;

  localparam logic [2:0] M_LOGON     = 3'd0;
  localparam logic [2:0] M_LIVE      = 3'd1;
  localparam logic [2:0] M_RECOVERED = 3'd2;
  localparam logic [2:0] M_REC_END   = 3'd3;
  localparam logic [2:0] M_DRAIN     = 3'd4;
  localparam logic [2:0] M_LOAD      = 3'd5;

  localparam logic [3:0] K_ACCEPT   = 4'd0;
  localparam logic [3:0] K_HELD     = 4'd1;
  localparam logic [3:0] K_DUP      = 4'd2;
  localparam logic [3:0] K_REJECT   = 4'd3;
  localparam logic [3:0] K_RELEASE  = 4'd4;
  localparam logic [3:0] K_RESEND   = 4'd5;
  localparam logic [3:0] K_STATUS   = 4'd6;
  localparam logic [3:0] K_OVERFLOW = 4'd7;
  localparam logic [3:0] K_NONE     = 4'd8;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PRE_RS,
    S_ST,
    S_MSG,
    S_POST_RS,
    S_REL,
    S_NONE
  } state_t;

  typedef struct packed {
    logic ins;
    logic pop;
  } cell_ctl_t;

  function automatic logic s_lt(input logic [31:0] a, input logic [31:0] b);
    return $signed(a) < $signed(b);
  endfunction

endpackage

// ===== src/sgr_cell.sv =====
module sgr_cell import sgr_pkg::*; #(
  parameter int REF_BITS = RefBitsDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cell_ctl_t           ctl,
  input  logic [31:0]         new_seq,
  input  logic [REF_BITS-1:0] new_ref,
  input  logic                new_live,
  input  logic                new_app,
  input  logic                left_above,
  input  logic                left_v,
  input  logic [31:0]         left_seq,
  input  logic [REF_BITS-1:0] left_ref,
  input  logic                left_live,
  input  logic                left_app,
  input  logic                right_v,
  input  logic [31:0]         right_seq,
  input  logic [REF_BITS-1:0] right_ref,
  input  logic                right_live,
  input  logic                right_app,
  output logic                v,
  output logic [31:0]         seq,
  output logic [REF_BITS-1:0] ref_o,
  output logic                live,
  output logic                app,
  output logic                above,
  output logic                eq
);

  logic                v_r, v_nxt;
  logic [31:0]         seq_r, seq_nxt;
  logic [REF_BITS-1:0] ref_r, ref_nxt;
  logic                live_r, live_nxt;
  logic                app_r, app_nxt;

  // empty cells sit at the tail and count as above any key
  assign above = !v_r || s_lt(new_seq, seq_r);
  assign eq    = v_r && (seq_r == new_seq);

  always_comb begin
    v_nxt    = v_r;
    seq_nxt  = seq_r;
    ref_nxt  = ref_r;
    live_nxt = live_r;
    app_nxt  = app_r;
    if (ctl.pop) begin
      v_nxt    = right_v;
      seq_nxt  = right_seq;
      ref_nxt  = right_ref;
      live_nxt = right_live;
      app_nxt  = right_app;
    end else if (ctl.ins && above) begin
      if (left_above) begin
        v_nxt    = left_v;
        seq_nxt  = left_seq;
        ref_nxt  = left_ref;
        live_nxt = left_live;
        app_nxt  = left_app;
      end else begin
        v_nxt    = 1'b1;
        seq_nxt  = new_seq;
        ref_nxt  = new_ref;
        live_nxt = new_live;
        app_nxt  = new_app;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seq_r  <= seq_nxt;
    ref_r  <= ref_nxt;
    live_r <= live_nxt;
    app_r  <= app_nxt;
  end

  assign v     = v_r;
  assign seq   = seq_r;
  assign ref_o = ref_r;
  assign live  = live_r;
  assign app   = app_r;

endmodule

// ===== src/sequence_gap_resequencer_unit.sv =====
// An input beat steps through the sequencer states pre-resend, status, message, post-resend,
// release and none, and yields up to three plain beats; one that releases entries on drain
// or recovery end emits one release beat per released entry (at most 16).
// The unit takes no new input beat until the sequencer is idle again; the sequencer emits
// at most one result beat per cycle and, while the output is not stalled, the release loop
// pops the head cell of the sorted hold chain once per cycle.
// Reset (rst_n low, synchronous): last number 0, hold chain empty, drain disarmed,
// drain limit 10, no result pending.
module sequence_gap_resequencer_unit import sgr_pkg::*; #(
  parameter int HOLD_DEPTH = HoldDepthDef,
  parameter int REF_BITS   = RefBitsDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          in_mode,
  input  logic [31:0]         in_seq_no,
  input  logic [REF_BITS-1:0] in_msg_ref,
  input  logic                in_is_logon,
  input  logic                in_is_app,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [3:0]          out_kind,
  output logic [31:0]         out_out_seq,
  output logic [REF_BITS-1:0] out_out_ref,
  output logic                out_live_flag,
  output logic [31:0]         out_range_begin,
  output logic [31:0]         out_range_end,
  output logic                out_open_end,
  output logic [31:0]         out_local_seq,
  output logic [31:0]         out_remote_seq,
  output logic                out_restore_flag,
  output logic                out_from_logon,
  output logic                out_last,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [0:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  // ---------------------------------------------------------------- state
  state_t              state_r, state_nxt;
  logic [31:0]         last_seq_r, last_seq_nxt;
  logic                armed_r, armed_nxt;
  logic [7:0]          limit_r;

  // captured input beat and its plan of result beats
  logic [2:0]          mode_r, mode_nxt;
  logic [31:0]         seq_r, seq_nxt;
  logic [REF_BITS-1:0] ref_r, ref_nxt;
  logic                live_r, live_nxt;
  logic                app_r, app_nxt;
  logic [3:0]          msg_kind_r, msg_kind_nxt;
  logic                pre_rs_r, pre_rs_nxt;
  logic                st_en_r, st_en_nxt;
  logic                msg_en_r, msg_en_nxt;
  logic                post_rs_r, post_rs_nxt;
  logic                rel_en_r, rel_en_nxt;
  logic                none_en_r, none_en_nxt;
  logic [31:0]         rs_beg_r, rs_beg_nxt;
  logic [31:0]         rs_end_r, rs_end_nxt;
  logic                rs_open_r, rs_open_nxt;
  logic [31:0]         st_loc_r, st_loc_nxt;
  logic [31:0]         st_rem_r, st_rem_nxt;
  logic                st_restore_r, st_restore_nxt;
  logic                st_logon_r, st_logon_nxt;
  logic [RES_CNT_W-1:0] rel_cnt_r, rel_cnt_nxt;
  logic [RES_CNT_W-1:0] app_cnt_r, app_cnt_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  logic [3:0]          o_kind_r;
  logic [31:0]         o_seq_r;
  logic [REF_BITS-1:0] o_ref_r;
  logic                o_live_r;
  logic [31:0]         o_rbeg_r, o_rend_r;
  logic                o_open_r;
  logic [31:0]         o_loc_r, o_rem_r;
  logic                o_restore_r, o_logon_r, o_last_r;

  // beat being built this cycle
  logic                emit;
  logic [3:0]          it_kind;
  logic [31:0]         it_seq;
  logic [REF_BITS-1:0] it_ref;
  logic                it_live;
  logic [31:0]         it_rbeg, it_rend;
  logic                it_open;
  logic [31:0]         it_loc, it_rem;
  logic                it_restore, it_logon, it_last;

  // ---------------------------------------------------------------- hold chain
  cell_ctl_t           ctl;
  logic                cell_v     [HOLD_DEPTH];
  logic [31:0]         cell_seq   [HOLD_DEPTH];
  logic [REF_BITS-1:0] cell_ref   [HOLD_DEPTH];
  logic                cell_live  [HOLD_DEPTH];
  logic                cell_app   [HOLD_DEPTH];
  logic                cell_above [HOLD_DEPTH];
  logic [HOLD_DEPTH-1:0] eq_vec;
  logic [HOLD_DEPTH-1:0] v_vec;

  // cell 0 holds the lowest key; keys rise along the chain and empty cells trail
  for (genvar i = 0; i < HOLD_DEPTH; i++) begin : g_cell
    logic                l_above, l_v, l_live, l_app;
    logic [31:0]         l_seq;
    logic [REF_BITS-1:0] l_ref;
    logic                r_v, r_live, r_app;
    logic [31:0]         r_seq;
    logic [REF_BITS-1:0] r_ref;
    logic                eq_o;

    if (i == 0) begin : g_head
      assign l_above = 1'b0;
      assign l_v     = 1'b0;
      assign l_seq   = '0;
      assign l_ref   = '0;
      assign l_live  = 1'b0;
      assign l_app   = 1'b0;
    end else begin : g_mid
      assign l_above = cell_above[i-1];
      assign l_v     = cell_v[i-1];
      assign l_seq   = cell_seq[i-1];
      assign l_ref   = cell_ref[i-1];
      assign l_live  = cell_live[i-1];
      assign l_app   = cell_app[i-1];
    end

    if (i == HOLD_DEPTH - 1) begin : g_tail
      assign r_v    = 1'b0;
      assign r_seq  = '0;
      assign r_ref  = '0;
      assign r_live = 1'b0;
      assign r_app  = 1'b0;
    end else begin : g_body
      assign r_v    = cell_v[i+1];
      assign r_seq  = cell_seq[i+1];
      assign r_ref  = cell_ref[i+1];
      assign r_live = cell_live[i+1];
      assign r_app  = cell_app[i+1];
    end

    sgr_cell #(.REF_BITS(REF_BITS)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .new_seq    (seq_r),
      .new_ref    (ref_r),
      .new_live   (live_r),
      .new_app    (app_r),
      .left_above (l_above),
      .left_v     (l_v),
      .left_seq   (l_seq),
      .left_ref   (l_ref),
      .left_live  (l_live),
      .left_app   (l_app),
      .right_v    (r_v),
      .right_seq  (r_seq),
      .right_ref  (r_ref),
      .right_live (r_live),
      .right_app  (r_app),
      .v          (cell_v[i]),
      .seq        (cell_seq[i]),
      .ref_o      (cell_ref[i]),
      .live       (cell_live[i]),
      .app        (cell_app[i]),
      .above      (cell_above[i]),
      .eq         (eq_o)
    );

    assign eq_vec[i] = eq_o;
    assign v_vec[i]  = cell_v[i];
  end

  logic chain_full, eq_any;
  assign chain_full = cell_v[HOLD_DEPTH-1];
  assign eq_any     = |eq_vec;

  // second cell seen by the release loop, after the head pops
  logic        nx_v;
  logic [31:0] nx_seq;
  if (HOLD_DEPTH > 1) begin : g_nx
    assign nx_v   = cell_v[1];
    assign nx_seq = cell_seq[1];
  end

  // ---------------------------------------------------------------- config port
  assign pready = 1'b1;
  assign prdata = (paddr == 1'b0) ? {24'd0, limit_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= DRAIN_RESET;
    end else if (psel && penable && pwrite && (paddr == 1'b0)) begin
      limit_r <= pwdata[7:0];
    end
  end

  // ---------------------------------------------------------------- sequencer
  logic        in_acc, emit_ok, positive;
  logic [31:0] beg, seq_m1;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && (state_r == S_IDLE);
  assign emit_ok  = !out_valid_r || !out_stall;
  assign positive = (in_seq_no != 32'd0) && !in_seq_no[31];
  assign beg      = last_seq_r + 32'd1;
  assign seq_m1   = in_seq_no - 32'd1;

  always_comb begin
    logic cont;
    logic [RES_CNT_W-1:0] app_add;

    state_nxt      = state_r;
    last_seq_nxt   = last_seq_r;
    armed_nxt      = armed_r;
    mode_nxt       = mode_r;
    seq_nxt        = seq_r;
    ref_nxt        = ref_r;
    live_nxt       = live_r;
    app_nxt        = app_r;
    msg_kind_nxt   = msg_kind_r;
    pre_rs_nxt     = pre_rs_r;
    st_en_nxt      = st_en_r;
    msg_en_nxt     = msg_en_r;
    post_rs_nxt    = post_rs_r;
    rel_en_nxt     = rel_en_r;
    none_en_nxt    = none_en_r;
    rs_beg_nxt     = rs_beg_r;
    rs_end_nxt     = rs_end_r;
    rs_open_nxt    = rs_open_r;
    st_loc_nxt     = st_loc_r;
    st_rem_nxt     = st_rem_r;
    st_restore_nxt = st_restore_r;
    st_logon_nxt   = st_logon_r;
    rel_cnt_nxt    = rel_cnt_r;
    app_cnt_nxt    = app_cnt_r;
    ctl            = '0;
    cont           = 1'b0;
    app_add        = '0;

    emit       = 1'b0;
    it_kind    = K_NONE;
    it_seq     = '0;
    it_ref     = '0;
    it_live    = 1'b0;
    it_rbeg    = '0;
    it_rend    = '0;
    it_open    = 1'b0;
    it_loc     = '0;
    it_rem     = '0;
    it_restore = 1'b0;
    it_logon   = 1'b0;
    it_last    = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          // capture the beat and lay out its result plan
          mode_nxt       = in_mode;
          seq_nxt        = in_seq_no;
          ref_nxt        = in_msg_ref;
          live_nxt       = 1'b0;
          app_nxt        = in_is_app;
          msg_kind_nxt   = K_ACCEPT;
          pre_rs_nxt     = 1'b0;
          st_en_nxt      = 1'b0;
          msg_en_nxt     = 1'b0;
          post_rs_nxt    = 1'b0;
          rel_en_nxt     = 1'b0;
          rs_beg_nxt     = beg;
          rs_end_nxt     = seq_m1;
          rs_open_nxt    = 1'b0;
          st_loc_nxt     = last_seq_r;
          st_rem_nxt     = in_seq_no;
          st_restore_nxt = 1'b0;
          st_logon_nxt   = 1'b0;
          rel_cnt_nxt    = '0;
          app_cnt_nxt    = '0;
          unique case (in_mode)
            M_LOGON: begin
              st_en_nxt    = 1'b1;
              st_logon_nxt = 1'b1;
              rs_open_nxt  = 1'b1;
              rs_end_nxt   = 32'hFFFF_FFFF;
              if (positive) begin
                st_rem_nxt = seq_m1;
                if (seq_m1 == last_seq_r) begin
                  // in step with the peer: status only
                end else if (s_lt(last_seq_r, seq_m1)) begin
                  pre_rs_nxt     = 1'b1;
                  st_restore_nxt = 1'b1;
                end else begin
                  last_seq_nxt = seq_m1;
                end
              end else begin
                pre_rs_nxt     = 1'b1;
                st_restore_nxt = 1'b1;
              end
            end
            M_LIVE: begin
              msg_en_nxt = 1'b1;
              live_nxt   = !in_is_logon;
              if (!positive) begin
                msg_kind_nxt = K_REJECT;
              end else if (s_lt(last_seq_r, in_seq_no)) begin
                if (in_seq_no == beg) begin
                  last_seq_nxt = in_seq_no;
                end else begin
                  msg_kind_nxt = K_HELD;
                  post_rs_nxt  = 1'b1;
                end
              end else begin
                // peer restarted: reset to its number
                st_en_nxt      = 1'b1;
                st_restore_nxt = 1'b1;
                last_seq_nxt   = in_seq_no;
                if (in_seq_no != 32'd1) begin
                  msg_kind_nxt = K_HELD;
                  post_rs_nxt  = 1'b1;
                  rs_beg_nxt   = 32'd1;
                end
              end
            end
            M_RECOVERED: begin
              msg_en_nxt = 1'b1;
              if (in_seq_no == beg) begin
                last_seq_nxt = in_seq_no;
                armed_nxt    = 1'b1;
              end else begin
                msg_kind_nxt = K_HELD;
              end
            end
            M_REC_END: begin
              if (positive) begin
                if (!cell_v[0]) begin
                  last_seq_nxt = in_seq_no;
                end else if (s_lt(in_seq_no, cell_seq[0])) begin
                  last_seq_nxt = in_seq_no;
                  armed_nxt    = 1'b1;
                end else begin
                  armed_nxt  = 1'b0;
                  rel_en_nxt = 1'b1;
                end
              end
            end
            M_DRAIN: begin
              if (armed_r) begin
                if (!cell_v[0]) begin
                  armed_nxt = 1'b0;
                end else if (cell_seq[0] == beg) begin
                  rel_en_nxt = 1'b1;
                end
              end
            end
            M_LOAD: begin
              last_seq_nxt = in_seq_no;
            end
            default: begin
            end
          endcase
          none_en_nxt = !(st_en_nxt || msg_en_nxt || pre_rs_nxt || rel_en_nxt);
          state_nxt   = S_PRE_RS;
        end
      end

      S_PRE_RS: begin
        if (!pre_rs_r) begin
          state_nxt = S_ST;
        end else if (emit_ok) begin
          emit      = 1'b1;
          it_kind   = K_RESEND;
          it_rbeg   = rs_beg_r;
          it_rend   = rs_end_r;
          it_open   = rs_open_r;
          state_nxt = S_ST;
        end
      end

      S_ST: begin
        if (!st_en_r) begin
          state_nxt = S_MSG;
        end else if (emit_ok) begin
          emit       = 1'b1;
          it_kind    = K_STATUS;
          it_loc     = st_loc_r;
          it_rem     = st_rem_r;
          it_restore = st_restore_r;
          it_logon   = st_logon_r;
          it_last    = !(msg_en_r || post_rs_r);
          state_nxt  = S_MSG;
        end
      end

      S_MSG: begin
        if (!msg_en_r) begin
          state_nxt = S_POST_RS;
        end else if (emit_ok) begin
          emit    = 1'b1;
          it_seq  = seq_r;
          it_ref  = ref_r;
          it_last = !post_rs_r;
          if (msg_kind_r == K_HELD) begin
            it_live = live_r;
            // an existing key wins; a full chain drops the message
            if (eq_any) begin
              it_kind = K_DUP;
            end else if (chain_full) begin
              it_kind = K_OVERFLOW;
            end else begin
              it_kind = K_HELD;
              ctl.ins = 1'b1;
            end
          end else begin
            it_kind = msg_kind_r;
          end
          state_nxt = S_POST_RS;
        end
      end

      S_POST_RS: begin
        if (!post_rs_r) begin
          state_nxt = S_REL;
        end else if (emit_ok) begin
          emit      = 1'b1;
          it_kind   = K_RESEND;
          it_rbeg   = rs_beg_r;
          it_rend   = rs_end_r;
          it_open   = rs_open_r;
          it_last   = 1'b1;
          state_nxt = S_REL;
        end
      end

      S_REL: begin
        if (!rel_en_r) begin
          state_nxt = S_NONE;
        end else if (emit_ok) begin
          // pop the head and decide from the next cell whether to go on
          emit         = 1'b1;
          it_kind      = K_RELEASE;
          it_seq       = cell_seq[0];
          it_ref       = cell_ref[0];
          it_live      = cell_live[0];
          ctl.pop      = 1'b1;
          last_seq_nxt = cell_seq[0];
          rel_cnt_nxt  = rel_cnt_r + 1'b1;
          app_add      = {{(RES_CNT_W-1){1'b0}}, cell_app[0]};
          app_cnt_nxt  = app_cnt_r + app_add;
          if (mode_r == M_REC_END) begin
            cont = nx_v && !s_lt(seq_r, nx_seq) && (rel_cnt_nxt < MAX_RES);
          end else begin
            cont = nx_v && ({3'd0, app_cnt_nxt} < limit_r) &&
                   (nx_seq == cell_seq[0] + 32'd1) && (rel_cnt_nxt < MAX_RES);
          end
          it_last = !cont;
          if (!cont) begin
            if (mode_r == M_REC_END) begin
              armed_nxt = nx_v;
            end
            state_nxt = S_IDLE;
          end
        end
      end

      S_NONE: begin
        if (!none_en_r) begin
          state_nxt = S_IDLE;
        end else if (emit_ok) begin
          emit      = 1'b1;
          it_kind   = K_NONE;
          it_last   = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // hold the result beat until taken
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      last_seq_r  <= '0;
      armed_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_seq_r  <= last_seq_nxt;
      armed_r     <= armed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    seq_r        <= seq_nxt;
    ref_r        <= ref_nxt;
    live_r       <= live_nxt;
    app_r        <= app_nxt;
    msg_kind_r   <= msg_kind_nxt;
    pre_rs_r     <= pre_rs_nxt;
    st_en_r      <= st_en_nxt;
    msg_en_r     <= msg_en_nxt;
    post_rs_r    <= post_rs_nxt;
    rel_en_r     <= rel_en_nxt;
    none_en_r    <= none_en_nxt;
    rs_beg_r     <= rs_beg_nxt;
    rs_end_r     <= rs_end_nxt;
    rs_open_r    <= rs_open_nxt;
    st_loc_r     <= st_loc_nxt;
    st_rem_r     <= st_rem_nxt;
    st_restore_r <= st_restore_nxt;
    st_logon_r   <= st_logon_nxt;
    rel_cnt_r    <= rel_cnt_nxt;
    app_cnt_r    <= app_cnt_nxt;
    if (emit) begin
      o_kind_r    <= it_kind;
      o_seq_r     <= it_seq;
      o_ref_r     <= it_ref;
      o_live_r    <= it_live;
      o_rbeg_r    <= it_rbeg;
      o_rend_r    <= it_rend;
      o_open_r    <= it_open;
      o_loc_r     <= it_loc;
      o_rem_r     <= it_rem;
      o_restore_r <= it_restore;
      o_logon_r   <= it_logon;
      o_last_r    <= it_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = o_kind_r;
  assign out_out_seq      = o_seq_r;
  assign out_out_ref      = o_ref_r;
  assign out_live_flag    = o_live_r;
  assign out_range_begin  = o_rbeg_r;
  assign out_range_end    = o_rend_r;
  assign out_open_end     = o_open_r;
  assign out_local_seq    = o_loc_r;
  assign out_remote_seq   = o_rem_r;
  assign out_restore_flag = o_restore_r;
  assign out_from_logon   = o_logon_r;
  assign out_last         = o_last_r;

  // ---------------------------------------------------------------- checks
  // occupied cells form an unbroken run from the head
  a_chain_packed: assert property (@(posedge clk) disable iff (!rst_n)
    ((v_vec & (v_vec + 1'b1)) == '0))
    else $error("hold chain has a gap");

  // the head key stays strictly below the second key
  a_chain_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    nx_v |-> s_lt(cell_seq[0], nx_seq))
    else $error("hold chain out of order");

  // a taken input beat starts the sequencer
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != S_IDLE))
    else $error("input beat taken but sequencer idle");

endmodule
